// ===== src/scf_pkg.sv =====
// ----------------------------------------------------------------------------
// scf_pkg
// Shared types and constants for the servo command frame encoder.
// ----------------------------------------------------------------------------
package scf_pkg;

  localparam logic [7:0]  FRAME_HEAD    = 8'h55;
  localparam logic [7:0]  CMD_MOVE      = 8'd1;
  localparam logic [7:0]  CMD_STOP      = 8'd12;
  localparam logic [7:0]  LEN_MOVE      = 8'd7;   // four parameters plus overhead
  localparam logic [7:0]  LEN_STOP      = 8'd3;
  localparam logic [15:0] ANGLE_MAX_Q8  = 16'd61440;
  localparam logic [20:0] ROUND_OFFSET  = 21'd768;
  localparam logic [15:0] RECIP_3       = 16'd43691;  // ceil(2^17 / 3)
  localparam int          RECIP_SHIFT   = 17;

  // byte positions within a frame
  localparam logic [3:0]  POS_HEAD0     = 4'd0;
  localparam logic [3:0]  POS_HEAD1     = 4'd1;
  localparam logic [3:0]  POS_ID        = 4'd2;
  localparam logic [3:0]  POS_LEN       = 4'd3;
  localparam logic [3:0]  POS_CMD       = 4'd4;
  localparam logic [3:0]  POS_P0        = 4'd5;
  localparam logic [3:0]  POS_P1        = 4'd6;
  localparam logic [3:0]  POS_P2        = 4'd7;
  localparam logic [3:0]  POS_P3        = 4'd8;
  localparam logic [3:0]  POS_LAST_MOVE = 4'd9;
  localparam logic [3:0]  POS_LAST_STOP = 4'd5;

  typedef enum logic {
    MODE_MOVE = 1'b0,
    MODE_STOP = 1'b1
  } mode_t;

  // one encoded command, ready to be sent byte by byte
  typedef struct packed {
    logic        valid;
    logic        stop;
    logic [7:0]  servo_id;
    logic [7:0]  raw_lo;
    logic [7:0]  raw_hi;
    logic [15:0] time_ms;
    logic [7:0]  chk;
  } frame_t;

endpackage

// ===== src/servo_command_frame_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// servo_command_frame_encoder_unit
// Turns one servo command into the bytes of its serial bus frame.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one command per transfer: mode, servo id,
// angle in Q8 degrees and move time. Output channel (out_valid/out_ready):
// one frame byte per transfer, out_frame_end high on the checksum byte.
// A move command gives 10 bytes, a stop command 6 bytes.
// A command is loaded into the angle scaling stage when it is accepted,
// then moves on to the checksum stage, from which its bytes are loaded into
// the output register; a stall can hold it at each step. Throughput is set
// by the byte sequencer, which sends one byte per cycle unless out_ready
// stalls it; frames follow back to back with no gap when the next command
// already waits in the scaling stage. While a frame is being sent from the
// checksum stage, one more command can wait in the scaling stage; once it
// is taken in_ready drops until the current frame's last byte is loaded.
// Reset empties the pipeline and the output register; no byte is presented
// until a new command arrives. When the receiver stalls, the current byte
// holds on the output and the pipeline fills, then in_ready drops.
// ----------------------------------------------------------------------------
module servo_command_frame_encoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_mode,
  input  logic [7:0]  in_servo_id,
  input  logic [23:0] in_angle_q8,
  input  logic [15:0] in_move_time_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_tx_byte,
  output logic        out_frame_end
);
  import scf_pkg::*;

  frame_t      frm;
  logic        frm_take;
  logic        load;
  logic        last;
  logic [7:0]  byte_sel;
  logic [3:0]  idx_r, idx_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_tx_byte_r;
  logic        out_frame_end_r;

  scf_frame_builder u_builder (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_servo_id     (in_servo_id),
    .in_angle_q8     (in_angle_q8),
    .in_move_time_ms (in_move_time_ms),
    .frm             (frm),
    .frm_take        (frm_take)
  );

  assign load     = frm.valid && (!out_valid_r || out_ready);
  assign last     = (idx_r == (frm.stop ? POS_LAST_STOP : POS_LAST_MOVE));
  assign frm_take = load && last;

  always_comb begin
    unique case (idx_r)
      POS_HEAD0, POS_HEAD1: byte_sel = FRAME_HEAD;
      POS_ID:               byte_sel = frm.servo_id;
      POS_LEN:              byte_sel = frm.stop ? LEN_STOP : LEN_MOVE;
      POS_CMD:              byte_sel = frm.stop ? CMD_STOP : CMD_MOVE;
      POS_P0:               byte_sel = frm.stop ? frm.chk : frm.raw_lo;
      POS_P1:               byte_sel = frm.raw_hi;
      POS_P2:               byte_sel = frm.time_ms[7:0];
      POS_P3:               byte_sel = frm.time_ms[15:8];
      default:              byte_sel = frm.chk;
    endcase
  end

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      idx_nxt       = last ? POS_HEAD0 : idx_r + 4'd1;
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= POS_HEAD0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_tx_byte_r   <= byte_sel;
      out_frame_end_r <= last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_tx_byte   = out_tx_byte_r;
  assign out_frame_end = out_frame_end_r;

endmodule

// ===== src/scf_frame_builder.sv =====
// ----------------------------------------------------------------------------
// scf_frame_builder
// Two-stage pipeline that scales the angle and forms the frame checksum.
// ----------------------------------------------------------------------------
module scf_frame_builder (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            in_mode,
  input  logic [7:0]      in_servo_id,
  input  logic [23:0]     in_angle_q8,
  input  logic [15:0]     in_move_time_ms,
  output scf_pkg::frame_t frm,
  input  logic            frm_take
);
  import scf_pkg::*;

  // stage a: clamp, scale by 25, round and drop the power-of-two part
  logic        a_valid_r, a_valid_nxt;
  logic        a_stop_r;
  logic [7:0]  a_id_r;
  logic [15:0] a_time_r;
  logic [11:0] a_y_r, a_y_nxt;

  // stage b: finished frame fields
  logic        b_valid_r, b_valid_nxt;
  logic        b_stop_r;
  logic [7:0]  b_id_r, b_raw_lo_r, b_raw_hi_r, b_chk_r;
  logic [15:0] b_time_r;

  logic        a_adv;
  logic [15:0] clamp_a;
  logic [20:0] scaled;
  logic [27:0] prod;
  logic [9:0]  raw;
  logic [7:0]  sum;

  assign a_adv    = a_valid_r && (!b_valid_r || frm_take);
  assign in_ready = !a_valid_r || a_adv;

  always_comb begin
    if (in_angle_q8[23]) begin
      clamp_a = '0;
    end else if (in_angle_q8[22:0] > {7'd0, ANGLE_MAX_Q8}) begin
      clamp_a = ANGLE_MAX_Q8;
    end else begin
      clamp_a = in_angle_q8[15:0];
    end
    scaled  = ({5'd0, clamp_a} << 4) + ({5'd0, clamp_a} << 3) + {5'd0, clamp_a}
              + ROUND_OFFSET;
    a_y_nxt = scaled[20:9];
  end

  // floor(y / 3) by reciprocal, exact for y below 2^15
  always_comb begin
    prod = {16'd0, a_y_r} * {12'd0, RECIP_3};
    raw  = prod[RECIP_SHIFT +: 10];
    if (a_stop_r) begin
      sum = a_id_r + LEN_STOP + CMD_STOP;
    end else begin
      sum = a_id_r + LEN_MOVE + CMD_MOVE + raw[7:0] + {6'd0, raw[9:8]}
            + a_time_r[7:0] + a_time_r[15:8];
    end
  end

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (in_valid && in_ready) begin
      a_valid_nxt = 1'b1;
    end else if (a_adv) begin
      a_valid_nxt = 1'b0;
    end
    b_valid_nxt = b_valid_r;
    if (a_adv) begin
      b_valid_nxt = 1'b1;
    end else if (frm_take) begin
      b_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
      b_valid_r <= b_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_stop_r <= (in_mode == MODE_STOP);
      a_id_r   <= in_servo_id;
      a_time_r <= in_move_time_ms;
      a_y_r    <= a_y_nxt;
    end
    if (a_adv) begin
      b_stop_r   <= a_stop_r;
      b_id_r     <= a_id_r;
      b_time_r   <= a_time_r;
      b_raw_lo_r <= raw[7:0];
      b_raw_hi_r <= {6'd0, raw[9:8]};
      b_chk_r    <= ~sum;
    end
  end

  always_comb begin
    frm.valid    = b_valid_r;
    frm.stop     = b_stop_r;
    frm.servo_id = b_id_r;
    frm.raw_lo   = b_raw_lo_r;
    frm.raw_hi   = b_raw_hi_r;
    frm.time_ms  = b_time_r;
    frm.chk      = b_chk_r;
  end

endmodule

// ===== src/scf_checker.sv =====
// ----------------------------------------------------------------------------
// scf_checker
// Port-level checks for the servo command frame encoder, bound to the top.
// ----------------------------------------------------------------------------
module scf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_tx_byte,
  input logic       out_frame_end
);
  import scf_pkg::*;

  // a stalled byte holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_tx_byte)
      && $stable(out_frame_end))
    else $error("output byte changed while stalled");

  // nothing is presented right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // bytes of one frame follow without gaps
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_frame_end |=> out_valid)
    else $error("gap inside a frame");

  // a new frame opens with the header byte
  a_head_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_frame_end |=> !out_valid || out_tx_byte == FRAME_HEAD)
    else $error("frame does not start with header");

endmodule

bind servo_command_frame_encoder_unit scf_checker u_scf_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_tx_byte   (out_tx_byte),
  .out_frame_end (out_frame_end)
);
